// ===== design/sfdw_pkg.sv =====
package sfdw_pkg;

  // Frame layout.
  localparam int unsigned FrameLen  = 8;
  localparam int unsigned FillWidth = $clog2(FrameLen);
  localparam logic [FillWidth-1:0] FillLast = FillWidth'(FrameLen - 1);

  localparam logic [7:0] MarkLeft  = 8'h4C;
  localparam logic [7:0] MarkRight = 8'h52;

  localparam logic [15:0] TimeoutReset = 16'd100;

  // Result word: fields from bit 0 up, padded to whole bytes.
  localparam int unsigned ResultWidth = 83;
  localparam int unsigned ResultBytesWidth = ((ResultWidth + 7) / 8) * 8;

  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_TICK = 1'b1
  } opcode_e;

  typedef struct packed {
    logic        restart_request;
    logic        online;
    logic [31:0] frame_count;
    logic [23:0] right_raw;
    logic [23:0] left_raw;
    logic        new_frame;
  } result_t;

endpackage

// ===== design/sensor_frame_deframer_watchdog_unit.sv =====
// Fixed-length frame deframer with a link watchdog. Each input transfer is
// either one received serial byte (tuser = 0) or one supervision tick
// (tuser = 1). Bytes are gathered into an 8-byte window that opens on 'L';
// a full window with 'L' at byte 0 and 'R' at byte 4 latches two 24-bit
// little-endian values and bumps the frame count, any other full window
// slides by one byte. Each tick advances a 32-bit time, judges the link
// online while a frame arrived fewer ticks ago than the programmed timeout,
// and while offline requests a receiver restart at most once per timeout.
// Every input transfer yields exactly one result transfer. The state update
// and the result are computed in the cycle the item is accepted and the
// result lands in the output register, so a new item is taken every cycle
// as long as the output side keeps draining. The timeout register can be
// written at any time the block is idle and resets to 100.
module sensor_frame_deframer_watchdog_unit
  import sfdw_pkg::*;
(
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [7:0]                  s_axis_tdata,  // data_byte[7:0]
  input  logic                        s_axis_tuser,  // opcode[0]
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // new_frame[0], left_raw[24:1], right_raw[48:25], frame_count[80:49],
  // online[81], restart_request[82], zero padding[87:83]
  output logic [ResultBytesWidth-1:0] m_axis_tdata,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [15:0]                 cfg_data_i
);

  logic [7:0]           win_q [FrameLen];
  logic [7:0]           win_d [FrameLen];
  logic [FillWidth-1:0] fill_q, fill_d;
  logic [23:0]          left_q, left_d;
  logic [23:0]          right_q, right_d;
  logic [31:0]          frames_q, frames_d;
  logic [31:0]          now_q, now_d;
  logic [31:0]          last_frame_q, last_frame_d;
  logic [31:0]          last_restart_q, last_restart_d;
  logic [31:0]          seen_q, seen_d;
  logic                 link_q, link_d;
  logic [15:0]          timeout_q;
  logic                 out_valid_q, out_valid_d;
  result_t              out_q, out_d;

  logic       in_xfer;
  opcode_e    opcode;
  logic [7:0] data_byte;
  logic       new_frame;
  logic       restart;
  logic       online;
  logic [31:0] timeout_ext;

  assign opcode      = opcode_e'(s_axis_tuser);
  assign data_byte   = s_axis_tdata;
  assign timeout_ext = {16'd0, timeout_q};

  // The output register frees up in the same cycle its result is taken.
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  always_comb begin
    win_d          = win_q;
    fill_d         = fill_q;
    left_d         = left_q;
    right_d        = right_q;
    frames_d       = frames_q;
    now_d          = now_q;
    last_frame_d   = last_frame_q;
    last_restart_d = last_restart_q;
    seen_d         = seen_q;
    link_d         = link_q;
    new_frame      = 1'b0;
    restart        = 1'b0;
    online         = 1'b0;
    if (in_xfer) begin
      case (opcode)
        OP_BYTE: begin
          // Nothing is gathered until a frame start shows up.
          if (fill_q != '0 || data_byte == MarkLeft) begin
            win_d[fill_q] = data_byte;
            if (fill_q == FillLast) begin
              if (win_q[0] == MarkLeft && win_q[4] == MarkRight) begin
                left_d    = {win_q[3], win_q[2], win_q[1]};
                right_d   = {data_byte, win_q[6], win_q[5]};
                frames_d  = frames_q + 32'd1;
                fill_d    = '0;
                new_frame = 1'b1;
              end else begin
                // Drop the oldest byte and keep the newest seven.
                for (int i = 0; i < FrameLen - 2; i++) begin
                  win_d[i] = win_q[i+1];
                end
                win_d[FrameLen-2] = data_byte;
                fill_d = FillLast;
              end
            end else begin
              fill_d = fill_q + FillWidth'(1);
            end
          end
        end
        OP_TICK: begin
          now_d = now_q + 32'd1;
          if (frames_q != seen_q) begin
            last_frame_d = now_d;
            seen_d       = frames_q;
          end
          online = (frames_q != 32'd0) && ((now_d - last_frame_d) < timeout_ext);
          link_d = online;
          if (!online && ((now_d - last_restart_q) >= timeout_ext)) begin
            last_restart_d = now_d;
            restart        = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (in_xfer) begin
      out_valid_d           = 1'b1;
      out_d.new_frame       = new_frame;
      out_d.left_raw        = left_d;
      out_d.right_raw       = right_d;
      out_d.frame_count     = frames_d;
      out_d.online          = link_d;
      out_d.restart_request = restart;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q         <= '0;
      left_q         <= '0;
      right_q        <= '0;
      frames_q       <= '0;
      now_q          <= '0;
      last_frame_q   <= '0;
      last_restart_q <= '0;
      seen_q         <= '0;
      link_q         <= 1'b0;
      timeout_q      <= TimeoutReset;
      out_valid_q    <= 1'b0;
    end else begin
      fill_q         <= fill_d;
      left_q         <= left_d;
      right_q        <= right_d;
      frames_q       <= frames_d;
      now_q          <= now_d;
      last_frame_q   <= last_frame_d;
      last_restart_q <= last_restart_d;
      seen_q         <= seen_d;
      link_q         <= link_d;
      out_valid_q    <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        timeout_q <= cfg_data_i;
      end
    end
  end

  // Window bytes and the result payload need no reset.
  always_ff @(posedge clk_i) begin
    win_q <= win_d;
    out_q <= out_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(ResultBytesWidth - ResultWidth)'(0), out_q};

`ifndef SYNTH
  a_frame_bumps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && new_frame |=> frames_q == $past(frames_q) + 32'd1)
    else $error("frame count did not advance on a completed frame");

  a_tick_advances_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && opcode == OP_TICK |=> now_q == $past(now_q) + 32'd1)
    else $error("time did not advance on a tick");

  a_online_needs_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.online |-> out_q.frame_count != 32'd0)
    else $error("link online without any frame");

  a_restart_only_offline: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.restart_request |-> !out_q.online && !out_q.new_frame)
    else $error("restart requested while online or on a byte");
`endif

endmodule

// ===== bench/sensor_frame_deframer_watchdog_unit_tb.sv =====
`timescale 1ns / 1ps

module sensor_frame_deframer_watchdog_unit_tb;
  import sfdw_pkg::*;

  localparam int unsigned RandomItems = 1900;
  localparam int unsigned RandomPhases = 10;
  localparam int unsigned CycleLimit = 500000;

  logic                        clk_i;
  logic                        rst_ni = 1'b0;
  logic                        s_axis_tvalid = 1'b0;
  logic                        s_axis_tready;
  logic [7:0]                  s_axis_tdata = '0;   // data_byte[7:0]
  logic                        s_axis_tuser = 1'b0; // opcode[0]
  logic                        m_axis_tvalid;
  logic                        m_axis_tready = 1'b0;
  // new_frame[0], left_raw[24:1], right_raw[48:25], frame_count[80:49],
  // online[81], restart_request[82], zero padding[87:83]
  logic [ResultBytesWidth-1:0] m_axis_tdata;
  logic                        cfg_valid_i = 1'b0;
  logic                        cfg_ready_o;
  logic [15:0]                 cfg_data_i = '0;

  sensor_frame_deframer_watchdog_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Predicted deframer and watchdog state.
  logic [7:0]  win_q [FrameLen] = '{default: 8'h00};
  int unsigned fill_q = 0;
  logic [23:0] left_q = '0;
  logic [23:0] right_q = '0;
  logic [31:0] frames_q = '0;
  logic [31:0] now_q = '0;
  logic [31:0] last_frame_q = '0;
  logic [31:0] last_restart_q = '0;
  logic [31:0] seen_frames_q = '0;
  logic        link_q = 1'b0;
  logic [15:0] timeout_q = TimeoutReset;

  result_t     pending_readings [$];
  int unsigned items_sent = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned burst_left = 0;

  int unsigned rx_seg_left = 0;
  int unsigned rx_period = 1;
  int unsigned rx_duty = 1;
  int unsigned rx_phase = 0;

  function automatic result_t deframe_predict(opcode_e op, logic [7:0] rx_byte);
    result_t reading;
    logic    fresh;
    logic    restart;
    logic    on;
    fresh = 1'b0;
    restart = 1'b0;
    if (op == OP_BYTE) begin
      // An empty window only opens on the left marker.
      if (fill_q != 0 || rx_byte == MarkLeft) begin
        win_q[fill_q] = rx_byte;
        fill_q++;
        if (fill_q == FrameLen) begin
          if (win_q[0] == MarkLeft && win_q[4] == MarkRight) begin
            left_q = {win_q[3], win_q[2], win_q[1]};
            right_q = {win_q[7], win_q[6], win_q[5]};
            frames_q = frames_q + 32'd1;
            fill_q = 0;
            fresh = 1'b1;
          end else begin
            for (int i = 0; i < FrameLen - 1; i++) win_q[i] = win_q[i + 1];
            fill_q = FrameLen - 1;
          end
        end
      end
    end else begin
      now_q = now_q + 32'd1;
      if (frames_q != seen_frames_q) begin
        last_frame_q = now_q;
        seen_frames_q = frames_q;
      end
      on = (frames_q != 32'd0) && ((now_q - last_frame_q) < {16'd0, timeout_q});
      link_q = on;
      if (!on && ((now_q - last_restart_q) >= {16'd0, timeout_q})) begin
        last_restart_q = now_q;
        restart = 1'b1;
      end
    end
    reading.new_frame = fresh;
    reading.left_raw = left_q;
    reading.right_raw = right_q;
    reading.frame_count = frames_q;
    reading.online = link_q;
    reading.restart_request = restart;
    return reading;
  endfunction

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 9))
      0: return MarkLeft;
      1: return MarkRight;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_item(opcode_e op, logic [7:0] rx_byte);
    int unsigned gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= rx_byte;
    s_axis_tuser <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_readings.push_back(deframe_predict(op, rx_byte));
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 60);
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12) : $urandom_range(1, 3);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_ticks(int unsigned count);
    repeat (count) send_item(OP_TICK, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_frame(logic [23:0] left_v, logic [23:0] right_v, logic [7:0] mark_r,
                            bit ticks_inside);
    logic [7:0] frame_bytes [FrameLen];
    frame_bytes = '{MarkLeft, left_v[7:0], left_v[15:8], left_v[23:16],
                    mark_r, right_v[7:0], right_v[15:8], right_v[23:16]};
    for (int i = 0; i < FrameLen; i++) begin
      // Ticks between bytes must leave the window untouched.
      if (ticks_inside && $urandom_range(0, 7) == 0) send_ticks(1);
      send_item(OP_BYTE, frame_bytes[i]);
    end
  endtask

  // Holds the sender off until every outstanding result has been checked.
  // The valid is dropped at once so that no stale item goes out meanwhile.
  task automatic drain_readings();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_readings.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_timeout(logic [15:0] ticks);
    drain_readings();
    repeat (3) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= ticks;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    timeout_q = ticks;
  endtask

  task automatic check_reading(result_t got);
    result_t want;
    if (pending_readings.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("%0t: unexpected result transfer %h", $realtime, got);
    end else begin
      want = pending_readings.pop_front();
      if (got.new_frame !== want.new_frame || got.left_raw !== want.left_raw ||
          got.right_raw !== want.right_raw || got.frame_count !== want.frame_count ||
          got.online !== want.online || got.restart_request !== want.restart_request) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("%0t: mismatch exp new=%b left=%h right=%h count=%h online=%b restart=%b",
                   $realtime, want.new_frame, want.left_raw, want.right_raw,
                   want.frame_count, want.online, want.restart_request);
          $display("%0t:          act new=%b left=%h right=%h count=%h online=%b restart=%b",
                   $realtime, got.new_frame, got.left_raw, got.right_raw,
                   got.frame_count, got.online, got.restart_request);
        end
      end
    end
  endtask

  // Receiver: each segment runs a ready pattern of its own period and duty.
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) check_reading(result_t'(m_axis_tdata[ResultWidth-1:0]));
    if (rx_seg_left == 0) begin
      rx_seg_left = $urandom_range(16, 200);
      rx_period = $urandom_range(1, 8);
      rx_duty = ($urandom_range(0, 2) == 0) ? rx_period : $urandom_range(1, rx_period);
      rx_phase = 0;
    end
    rx_seg_left--;
    m_axis_tready <= rst_ni && (rx_phase < rx_duty);
    rx_phase = (rx_phase + 1) % rx_period;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("sensor_frame_deframer_watchdog_unit_tb: done, errors");
      $finish;
    end
  end

  task automatic test_default_timeout();
    send_ticks(3);
    send_frame(24'h123456, 24'h89ABCD, MarkRight, 1'b0);
    send_ticks(3);
  endtask

  task automatic test_frame_extremes();
    // Anything but the left marker is dropped while the window is empty.
    send_item(OP_BYTE, 8'h00);
    send_item(OP_BYTE, 8'hFF);
    send_frame(24'hFFFFFF, 24'hFFFFFF, MarkRight, 1'b0);
    // A stray left marker makes the first full window miss, so it slides once.
    send_item(OP_BYTE, MarkLeft);
    send_frame(24'h000000, 24'h000000, MarkRight, 1'b0);
    send_item(OP_TICK, 8'hFF);
    send_item(OP_TICK, 8'h00);
  endtask

  task automatic test_timeout_extremes();
    write_timeout(16'd1);
    send_ticks(3);
    send_frame(24'hA5A5A5, 24'h5A5A5A, MarkRight, 1'b0);
    send_ticks(3);
    // A zero timeout keeps the link down and restarts on every tick.
    write_timeout(16'd0);
    send_ticks(2);
    send_frame(24'h010203, 24'h040506, MarkRight, 1'b0);
    send_ticks(2);
    write_timeout(16'hFFFF);
    send_frame(24'h7F8081, 24'hFEDCBA, MarkRight, 1'b0);
    send_ticks(3);
  endtask

  task automatic test_random_traffic();
    int unsigned phase_goal;
    int unsigned tick_max;
    logic [15:0] ticks;
    logic [7:0]  mark_r;
    for (int phase = 0; phase < RandomPhases; phase++) begin
      case ($urandom_range(0, 9))
        0: ticks = 16'd0;
        1: ticks = 16'hFFFF;
        2: ticks = 16'($urandom_range(25, 65535));
        default: ticks = 16'($urandom_range(1, 24));
      endcase
      if (phase == 0) ticks = 16'd1;
      write_timeout(ticks);
      tick_max = (ticks == 0) ? 2 : ((ticks > 14) ? 30 : 2 * ticks + 2);
      phase_goal = items_sent + RandomItems / RandomPhases;
      while (items_sent < phase_goal) begin
        if (phase == 3 && $urandom_range(0, 99) == 0) drain_readings();
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: begin
            mark_r = ($urandom_range(0, 5) == 0) ? rand_byte() : MarkRight;
            send_frame({rand_byte(), rand_byte(), rand_byte()},
                       {rand_byte(), rand_byte(), rand_byte()},
                       mark_r, $urandom_range(0, 3) == 0);
          end
          5, 6, 7: send_ticks($urandom_range(1, tick_max));
          8: repeat ($urandom_range(1, 6)) send_item(OP_BYTE, 8'($urandom_range(0, 255)));
          default: begin
            send_item(OP_BYTE, MarkLeft);
            repeat ($urandom_range(1, 6)) send_item(OP_BYTE, rand_byte());
          end
        endcase
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_default_timeout();
    test_frame_extremes();
    test_timeout_extremes();
    test_random_traffic();
    drain_readings();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0)
      $display("sensor_frame_deframer_watchdog_unit_tb: done, clean");
    else
      $display("sensor_frame_deframer_watchdog_unit_tb: done, errors");
    $finish;
  end

endmodule

// ===== sensor_frame_deframer_watchdog_unit.f =====
design/sfdw_pkg.sv
design/sensor_frame_deframer_watchdog_unit.sv
bench/sensor_frame_deframer_watchdog_unit_tb.sv
